FILE: hw/rtl/wmsc_pkg.sv
// wmsc_pkg: shared types, field widths and constants of the windowed motion sleep classifier
// no dependencies; imported by every module of the block except wmsc_ram
`timescale 1ns / 1ps

package wmsc_pkg;

    // field widths
    localparam int MOVE_W     = 16;
    localparam int MOV_SUM_W  = 18;
    localparam int AXES_W     = 2;
    localparam int THR_W      = 18;
    localparam int CLASS_W    = 2;
    localparam int MEAN_MOV_W = 18;
    localparam int MEAN_AX_W  = 10;
    localparam int FRAC_W     = 8;

    // value ranges used to size the running totals
    localparam int MOV_SUM_MAX = 196605;
    localparam int AXES_MAX    = 3;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_AWAKE_THR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_THR = 1'b1;

    // threshold reset values, Q8.8 (1.5 and 0.10)
    localparam int AWAKE_THR_RST = 384;
    localparam int LIGHT_THR_RST = 26;

    // default window length in samples
    localparam int WINDOW_LEN_DEF = 30;

    // pipeline depth of the constant divider and depth of the result queue
    localparam int CDIV_LAT    = 3;
    localparam int OFIFO_DEPTH = 8;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_AWAKE = 2'd0,
        CLASS_LIGHT = 2'd1,
        CLASS_DEEP  = 2'd2
    } t_sleep_class;

    typedef struct packed {
        t_sleep_class          sleep_class;
        logic [MEAN_MOV_W-1:0] mean_movement;
        logic [MEAN_AX_W-1:0]  mean_axes;
    } t_result;

endpackage

FILE: hw/rtl/wmsc_ram.sv
// wmsc_ram: generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module wmsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/wmsc_cdiv.sv
// wmsc_cdiv: pipelined division by a constant through a reciprocal multiply and one correction
// depends on wmsc_pkg for the default divisor; three register stages
`timescale 1ns / 1ps

module wmsc_cdiv
    import wmsc_pkg::*;
#(
    parameter int IN_W    = 23,
    parameter int OUT_W   = 18,
    parameter int DIVISOR = WINDOW_LEN_DEF
) (
    input  logic             i_clk,
    input  logic [IN_W-1:0]  i_num,
    output logic [OUT_W-1:0] o_quot
);

    localparam int PROD_W = 2 * IN_W;
    // floor(2^IN_W / DIVISOR): the estimate is low by at most one
    localparam logic [IN_W-1:0] RECIP = IN_W'((64'd1 << IN_W) / DIVISOR);
    localparam logic [IN_W-1:0] DIV_C = IN_W'(DIVISOR);

    logic [PROD_W-1:0] r_prod;
    logic [IN_W-1:0]   r_num1;
    logic [IN_W-1:0]   r_qest;
    logic [IN_W-1:0]   r_rem;
    logic [IN_W-1:0]   r_quot;
    logic [IN_W-1:0]   w_qest;
    logic [IN_W-1:0]   w_back;

    // stage 1: reciprocal multiply
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_num) * PROD_W'(RECIP);
        r_num1 <= i_num;
    end

    // stage 2: estimate and remainder
    assign w_qest = r_prod[PROD_W-1:IN_W];
    assign w_back = w_qest * DIV_C;

    always_ff @(posedge i_clk) begin
        r_qest <= w_qest;
        r_rem  <= r_num1 - w_back;
    end

    // stage 3: correct the estimate when the remainder reaches the divisor
    always_ff @(posedge i_clk) begin
        r_quot <= r_qest + IN_W'(r_rem >= DIV_C);
    end

    assign o_quot = r_quot[OUT_W-1:0];

endmodule

FILE: hw/rtl/wmsc_ofifo.sv
// wmsc_ofifo: small register queue holding finished results until the receiver takes them
// depends on wmsc_pkg for the result struct
`timescale 1ns / 1ps

module wmsc_ofifo
    import wmsc_pkg::*;
#(
    parameter int DEPTH = OFIFO_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr,
    input  t_result                    i_wdata,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output logic                       o_valid,
    input  logic                       i_ready,
    output t_result                    o_rdata
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_rd;

    assign o_valid = (r_count != '0);
    assign w_rd    = o_valid && i_ready;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr && w_rd) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_count = r_count;
    assign o_rdata = r_mem[r_rd_ptr];

endmodule

FILE: hw/rtl/windowed_motion_sleep_classifier.sv
// windowed_motion_sleep_classifier: top level of the sliding window sleep classifier
// depends on wmsc_pkg, wmsc_ram, wmsc_cdiv and wmsc_ofifo
`timescale 1ns / 1ps

// Usage
//   Input channel (i_valid / o_ready): one sample per transfer, three Q8.8 axis
//   magnitudes and an active axis count. Output channel (o_valid / i_ready): one
//   result per sample once WINDOW_LEN samples have been seen: class and the
//   truncated window averages of movement and axis count.
//   Config port: i_cfg_wen writes i_cfg_data to the register at i_cfg_idx
//   (0 awake threshold, 1 light threshold); write only while the block is idle.
//   Throughput: one sample per cycle while o_ready is high, set by the single read and single write
//   of the window ring memory per sample.
//   Pipeline: a result passes the ring read, the running total update, the
//   constant divider stages and the result queue before it can be taken.
//   Reset (synchronous, active low) empties the pipeline and the result queue,
//   zeroes the totals and the window position and restores the thresholds.
//   The ring memory needs no clearing: old entries are used only after the
//   window has been filled once.
//   When the receiver stalls, results collect in an eight-entry queue and
//   o_ready drops only when the queue plus the items still in the pipeline
//   would fill it.

module windowed_motion_sleep_classifier
    import wmsc_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [THR_W-1:0]      i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [MOVE_W-1:0]     i_move_x,
    input  logic [MOVE_W-1:0]     i_move_y,
    input  logic [MOVE_W-1:0]     i_move_z,
    input  logic [AXES_W-1:0]     i_active_axis_count,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [CLASS_W-1:0]    o_sleep_class,
    output logic [MEAN_MOV_W-1:0] o_mean_movement,
    output logic [MEAN_AX_W-1:0]  o_mean_axes
);

    localparam int SLOT_W  = $clog2(WINDOW_LEN);
    localparam int MOV_TW  = $clog2(WINDOW_LEN * MOV_SUM_MAX + 1);
    localparam int AX_TW   = $clog2(AXES_MAX * WINDOW_LEN + 1);
    localparam int AXN_W   = AX_TW + FRAC_W;
    localparam int LIM_W   = THR_W + $clog2(WINDOW_LEN);
    localparam int CMP_W   = (MOV_TW > LIM_W) ? MOV_TW : LIM_W;
    localparam int RAM_W   = MOV_SUM_W + AXES_W;
    localparam int INFL_W  = $clog2(CDIV_LAT + 3);
    localparam int CNT_W   = $clog2(OFIFO_DEPTH + 1);
    localparam int OCC_W   = ((CNT_W > INFL_W) ? CNT_W : INFL_W) + 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);
    localparam logic [LIM_W-1:0]  AWAKE_LIM_RST = LIM_W'(AWAKE_THR_RST * WINDOW_LEN);
    localparam logic [LIM_W-1:0]  LIGHT_LIM_RST = LIM_W'(LIGHT_THR_RST * WINDOW_LEN);

    // thresholds kept already scaled by the window length
    logic [LIM_W-1:0]      r_awake_lim;
    logic [LIM_W-1:0]      r_light_lim;

    // window position
    logic [SLOT_W-1:0]     r_slot;
    logic                  r_filled;

    // accept stage
    logic                  w_accept;
    logic [MOV_SUM_W-1:0]  w_sum;
    logic                  r_a_valid;
    logic                  r_a_sub;
    logic                  r_a_emit;
    logic [MOV_SUM_W-1:0]  r_a_sum;
    logic [AXES_W-1:0]     r_a_axes;
    logic [SLOT_W-1:0]     r_a_slot;

    // running total stage
    logic [RAM_W-1:0]      w_ring_rdata;
    logic [MOV_SUM_W-1:0]  w_old_mov;
    logic [AXES_W-1:0]     w_old_axes;
    logic [MOV_TW-1:0]     r_mov_tot;
    logic [MOV_TW-1:0]     n_mov_tot;
    logic [AX_TW-1:0]      r_ax_tot;
    logic [AX_TW-1:0]      n_ax_tot;
    logic                  r_b_valid;

    // classify and divide stages
    t_sleep_class          w_class;
    logic [CDIV_LAT-1:0]   r_d_valid;
    t_sleep_class          r_d_class [CDIV_LAT];
    logic [MEAN_MOV_W-1:0] w_mean_mov;
    logic [MEAN_AX_W-1:0]  w_mean_ax;

    // result queue
    t_result               w_res_in;
    t_result               w_res_out;
    logic [CNT_W-1:0]      w_q_count;
    logic [INFL_W-1:0]     w_inflight;
    logic [OCC_W-1:0]      w_occupancy;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awake_lim <= AWAKE_LIM_RST;
            r_light_lim <= LIGHT_LIM_RST;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                CFG_AWAKE_THR: r_awake_lim <= LIM_W'(i_cfg_data) * LIM_W'(WINDOW_LEN);
                CFG_LIGHT_THR: r_light_lim <= LIM_W'(i_cfg_data) * LIM_W'(WINDOW_LEN);
                default: ;
            endcase
        end
    end

    // credit check: queue entries plus everything still in the pipeline
    assign w_inflight  = INFL_W'($countones({r_a_valid, r_b_valid, r_d_valid}));
    assign w_occupancy = OCC_W'(w_q_count) + OCC_W'(w_inflight);
    assign o_ready     = (w_occupancy < OCC_W'(OFIFO_DEPTH));
    assign w_accept    = i_valid && o_ready;

    // accept stage: sum the axes and read the entry about to be replaced
    assign w_sum = MOV_SUM_W'(i_move_x) + MOV_SUM_W'(i_move_y) + MOV_SUM_W'(i_move_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_filled  <= 1'b0;
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= w_accept;
            if (w_accept) begin
                r_slot <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
                if (r_slot == LAST_SLOT) begin
                    r_filled <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_sum  <= w_sum;
            r_a_axes <= i_active_axis_count;
            r_a_slot <= r_slot;
            r_a_sub  <= r_filled;
            r_a_emit <= r_filled || (r_slot == LAST_SLOT);
        end
    end

    // window ring: read at accept, written back in the following cycle
    wmsc_ram #(
        .WIDTH (RAM_W),
        .DEPTH (WINDOW_LEN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_a_valid),
        .i_waddr (r_a_slot),
        .i_wdata ({r_a_sum, r_a_axes}),
        .i_re    (w_accept),
        .i_raddr (r_slot),
        .o_rdata (w_ring_rdata)
    );

    // running totals: drop the outgoing entry once the window is full
    assign w_old_mov  = w_ring_rdata[RAM_W-1:AXES_W];
    assign w_old_axes = w_ring_rdata[AXES_W-1:0];

    always_comb begin
        n_mov_tot = r_mov_tot;
        n_ax_tot  = r_ax_tot;
        if (r_a_valid) begin
            n_mov_tot = r_mov_tot - (r_a_sub ? MOV_TW'(w_old_mov) : '0) + MOV_TW'(r_a_sum);
            n_ax_tot  = r_ax_tot - (r_a_sub ? AX_TW'(w_old_axes) : '0) + AX_TW'(r_a_axes);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mov_tot <= '0;
            r_ax_tot  <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_mov_tot <= n_mov_tot;
            r_ax_tot  <= n_ax_tot;
            r_b_valid <= r_a_valid && r_a_emit;
        end
    end

    // classification against the scaled thresholds
    always_comb begin
        if (CMP_W'(r_mov_tot) > CMP_W'(r_awake_lim)) begin
            w_class = CLASS_AWAKE;
        end else if (CMP_W'(r_mov_tot) > CMP_W'(r_light_lim)) begin
            w_class = CLASS_LIGHT;
        end else begin
            w_class = CLASS_DEEP;
        end
    end

    // window averages
    wmsc_cdiv #(
        .IN_W    (MOV_TW),
        .OUT_W   (MEAN_MOV_W),
        .DIVISOR (WINDOW_LEN)
    ) u_div_mov (
        .i_clk  (i_clk),
        .i_num  (r_mov_tot),
        .o_quot (w_mean_mov)
    );

    wmsc_cdiv #(
        .IN_W    (AXN_W),
        .OUT_W   (MEAN_AX_W),
        .DIVISOR (WINDOW_LEN)
    ) u_div_axes (
        .i_clk  (i_clk),
        .i_num  ({r_ax_tot, FRAC_W'(0)}),
        .o_quot (w_mean_ax)
    );

    // valid and class follow the divider pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= '0;
        end else begin
            r_d_valid <= {r_d_valid[CDIV_LAT-2:0], r_b_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_class[0] <= w_class;
        for (int i = 1; i < CDIV_LAT; i++) begin
            r_d_class[i] <= r_d_class[i-1];
        end
    end

    // result queue
    assign w_res_in.sleep_class   = r_d_class[CDIV_LAT-1];
    assign w_res_in.mean_movement = w_mean_mov;
    assign w_res_in.mean_axes     = w_mean_ax;

    wmsc_ofifo #(
        .DEPTH (OFIFO_DEPTH)
    ) u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (r_d_valid[CDIV_LAT-1]),
        .i_wdata (w_res_in),
        .o_count (w_q_count),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rdata (w_res_out)
    );

    assign o_sleep_class   = w_res_out.sleep_class;
    assign o_mean_movement = w_res_out.mean_movement;
    assign o_mean_axes     = w_res_out.mean_axes;

endmodule

FILE: hw/rtl/wmsc_checker.sv
// wmsc_checker: port level assertions for the sleep classifier, bound to the top level
// depends on wmsc_pkg and on windowed_motion_sleep_classifier
`timescale 1ns / 1ps

module wmsc_checker
    import wmsc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [CLASS_W-1:0]    i_out_sleep_class,
    input logic [MEAN_MOV_W-1:0] i_out_mean_movement,
    input logic [MEAN_AX_W-1:0]  i_out_mean_axes
);

    localparam logic [MEAN_AX_W-1:0] MEAN_AX_MAX = MEAN_AX_W'(AXES_MAX << FRAC_W);

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    // a result carries one of the three classes
    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_sleep_class == CLASS_AWAKE) ||
                        (i_out_sleep_class == CLASS_LIGHT) ||
                        (i_out_sleep_class == CLASS_DEEP))
        else $error("result class outside awake, light, deep");

    // the axis average never exceeds three axes
    a_axes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_mean_axes <= MEAN_AX_MAX)
        else $error("axis average above three axes");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_sleep_class) &&
            $stable(i_out_mean_movement) && $stable(i_out_mean_axes))
        else $error("stalled result changed or dropped");

endmodule

bind windowed_motion_sleep_classifier wmsc_checker u_wmsc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_out_valid         (o_valid),
    .i_out_ready         (i_ready),
    .i_out_sleep_class   (o_sleep_class),
    .i_out_mean_movement (o_mean_movement),
    .i_out_mean_axes     (o_mean_axes)
);

FILE: bench/windowed_motion_sleep_classifier_tb.sv
// windowed_motion_sleep_classifier_tb: self-checking bench for the sliding window sleep classifier
// depends on wmsc_pkg and windowed_motion_sleep_classifier; predicts every result and compares
`timescale 1ns / 1ps

module windowed_motion_sleep_classifier_tb;
    import wmsc_pkg::*;

    localparam int WIN          = WINDOW_LEN_DEF;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 105;
    localparam int NUM_PHASES   = 8;
    localparam logic [MOVE_W-1:0] MOVE_MAX = '1;
    localparam logic [AXES_W-1:0] AXES_TOP = '1;
    localparam logic [THR_W-1:0]  THR_TOP  = '1;

    typedef struct packed {
        logic [MOVE_W-1:0] move_x;
        logic [MOVE_W-1:0] move_y;
        logic [MOVE_W-1:0] move_z;
        logic [AXES_W-1:0] axes;
    } t_motion_sample;

    // dut ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_AWAKE_THR;
    logic [THR_W-1:0]      i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [MOVE_W-1:0]     i_move_x = '0;
    logic [MOVE_W-1:0]     i_move_y = '0;
    logic [MOVE_W-1:0]     i_move_z = '0;
    logic [AXES_W-1:0]     i_active_axis_count = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [CLASS_W-1:0]    o_sleep_class;
    logic [MEAN_MOV_W-1:0] o_mean_movement;
    logic [MEAN_AX_W-1:0]  o_mean_axes;

    // classifier state as the bench sees it
    logic [THR_W-1:0]     awake_thr_q = THR_W'(AWAKE_THR_RST);
    logic [THR_W-1:0]     light_thr_q = THR_W'(LIGHT_THR_RST);
    logic [MOV_SUM_W-1:0] movement_window [WIN];
    logic [AXES_W-1:0]    axes_window [WIN];
    int unsigned          window_pos = 0;
    bit                   window_full = 1'b0;
    logic [31:0]          movement_sum = '0;
    logic [31:0]          axes_sum = '0;
    t_result              pending_results [$];

    // traffic shaping
    int unsigned idle_pct = 20;
    bit          no_idle = 1'b0;
    int unsigned hold_requests = 0;
    int unsigned holds_served = 0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;
    int unsigned level_cap = 64;
    int unsigned level_left = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    windowed_motion_sleep_classifier #(
        .WINDOW_LEN(WIN)
    ) u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wen           (i_cfg_wen),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_move_x            (i_move_x),
        .i_move_y            (i_move_y),
        .i_move_z            (i_move_z),
        .i_active_axis_count (i_active_axis_count),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_sleep_class       (o_sleep_class),
        .o_mean_movement     (o_mean_movement),
        .o_mean_axes         (o_mean_axes)
    );

    // clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("windowed_motion_sleep_classifier_tb: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    // window update and classification of one accepted sample
    task automatic classify_sample(input t_motion_sample s);
        logic [MOV_SUM_W-1:0] move_total;
        t_result              res;
        move_total = MOV_SUM_W'(s.move_x) + MOV_SUM_W'(s.move_y) + MOV_SUM_W'(s.move_z);
        if (window_full) begin
            movement_sum -= movement_window[window_pos];
            axes_sum     -= axes_window[window_pos];
        end
        movement_sum += move_total;
        axes_sum     += s.axes;
        movement_window[window_pos] = move_total;
        axes_window[window_pos]     = s.axes;
        window_pos++;
        if (window_pos >= WIN) begin
            window_full = 1'b1;
            window_pos  = 0;
        end
        if (window_full) begin
            if (movement_sum > 32'(awake_thr_q) * WIN)
                res.sleep_class = CLASS_AWAKE;
            else if (movement_sum > 32'(light_thr_q) * WIN)
                res.sleep_class = CLASS_LIGHT;
            else
                res.sleep_class = CLASS_DEEP;
            res.mean_movement = MEAN_MOV_W'(movement_sum / WIN);
            res.mean_axes     = MEAN_AX_W'((axes_sum * 256) / WIN);
            pending_results.push_back(res);
        end
    endtask

    // compare one output transfer with the oldest expected result
    task automatic check_result();
        t_result want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected (class %0d)", o_sleep_class));
        end else begin
            want = pending_results.pop_front();
            if (o_sleep_class !== want.sleep_class)
                report_mismatch($sformatf("sleep_class exp %0d got %0d",
                                          want.sleep_class, o_sleep_class));
            if (o_mean_movement !== want.mean_movement)
                report_mismatch($sformatf("mean_movement exp %0d got %0d",
                                          want.mean_movement, o_mean_movement));
            if (o_mean_axes !== want.mean_axes)
                report_mismatch($sformatf("mean_axes exp %0d got %0d",
                                          want.mean_axes, o_mean_axes));
        end
    endtask

    // result side: check transfers, random stalls and the long hold
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            check_result();
        if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (!no_idle && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(1, 12) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // one sample transfer, with an optional idle burst in front
    task automatic send_sample(input t_motion_sample s);
        int unsigned gap;
        if (!no_idle && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid             <= 1'b1;
        i_move_x            <= s.move_x;
        i_move_y            <= s.move_y;
        i_move_z            <= s.move_z;
        i_active_axis_count <= s.axes;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        classify_sample(s);
    endtask

    // wait until every expected result has come and the pipeline is empty
    task automatic await_drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write both thresholds on back-to-back cycles; only while idle
    task automatic set_thresholds(input logic [THR_W-1:0] awake, input logic [THR_W-1:0] light);
        i_cfg_wen  <= 1'b1;
        i_cfg_idx  <= CFG_AWAKE_THR;
        i_cfg_data <= awake;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LIGHT_THR;
        i_cfg_data <= light;
        @(posedge i_clk);
        i_cfg_wen  <= 1'b0;
        @(posedge i_clk);
        awake_thr_q = awake;
        light_thr_q = light;
    endtask

    function automatic t_motion_sample make_sample(input logic [MOVE_W-1:0] x,
                                                   input logic [MOVE_W-1:0] y,
                                                   input logic [MOVE_W-1:0] z,
                                                   input logic [AXES_W-1:0] axes);
        t_motion_sample s;
        s.move_x = x;
        s.move_y = y;
        s.move_z = z;
        s.axes   = axes;
        return s;
    endfunction

    // one axis value at the current activity level, sometimes an extreme
    function automatic logic [MOVE_W-1:0] random_axis();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(0, 1) ? MOVE_MAX : '0;
        return MOVE_W'($urandom_range(0, level_cap - 1));
    endfunction

    // random sample; activity level drifts so the window average wanders across classes
    function automatic t_motion_sample random_sample();
        if (level_left == 0) begin
            case ($urandom_range(0, 3))
                0: level_cap = 64;
                1: level_cap = 512;
                2: level_cap = 4096;
                default: level_cap = 65536;
            endcase
            level_left = $urandom_range(10, 40);
        end
        level_left--;
        return make_sample(random_axis(), random_axis(), random_axis(),
                           AXES_W'($urandom_range(0, 3)));
    endfunction

    // fill the window with full-scale samples; only the last one yields a result
    task automatic test_window_fill();
        int i;
        for (i = 0; i < WIN; i++)
            send_sample(make_sample(MOVE_MAX, MOVE_MAX, MOVE_MAX, AXES_TOP));
        await_drain();
    endtask

    // window total held at full scale while thresholds land exactly on it
    task automatic test_threshold_equal();
        t_motion_sample top;
        top = make_sample(MOVE_MAX, MOVE_MAX, MOVE_MAX, AXES_TOP);
        set_thresholds(THR_W'(MOV_SUM_MAX), THR_W'(LIGHT_THR_RST));
        send_sample(top);
        await_drain();
        set_thresholds(THR_W'(MOV_SUM_MAX), THR_W'(MOV_SUM_MAX));
        send_sample(top);
        await_drain();
        set_thresholds(THR_W'(MOV_SUM_MAX - 1), THR_W'(MOV_SUM_MAX));
        send_sample(top);
        await_drain();
        set_thresholds(THR_TOP, THR_W'(MOV_SUM_MAX - 1));
        send_sample(top);
        await_drain();
        set_thresholds(THR_TOP, THR_TOP);
        send_sample(top);
        await_drain();
    endtask

    // zero thresholds, window drains to an all-zero total equal to them
    task automatic test_drain_to_zero();
        int i;
        set_thresholds('0, '0);
        for (i = 0; i < WIN; i++)
            send_sample(make_sample('0, '0, '0, '0));
        await_drain();
    endtask

    // receiver holds off while samples keep coming, so the result queue fills
    task automatic test_backpressure();
        int i;
        set_thresholds(THR_W'(AWAKE_THR_RST), THR_W'(LIGHT_THR_RST));
        idle_pct = 0;
        hold_requests++;
        for (i = 0; i < 40; i++)
            send_sample(random_sample());
        await_drain();
    endtask

    // random phases, each with its own threshold setting and idle rate
    task automatic test_random_phases();
        int p;
        int i;
        logic [THR_W-1:0] awake;
        logic [THR_W-1:0] light;
        for (p = 0; p < NUM_PHASES; p++) begin
            idle_pct = $urandom_range(5, 35);
            case (p)
                0: begin
                    awake = THR_W'(AWAKE_THR_RST);
                    light = THR_W'(LIGHT_THR_RST);
                end
                // light threshold above awake threshold
                2: begin
                    awake = THR_W'(100);
                    light = THR_W'(3000);
                end
                // full-range register values
                4: begin
                    awake = THR_W'($urandom_range(0, 262143));
                    light = THR_W'($urandom_range(0, 262143));
                end
                // a stretch with no idling at all
                5: begin
                    awake = THR_W'($urandom_range(0, 12000));
                    light = THR_W'($urandom_range(0, 3000));
                    idle_pct = 0;
                end
                // last part: defaults, no idling
                NUM_PHASES - 1: begin
                    awake = THR_W'(AWAKE_THR_RST);
                    light = THR_W'(LIGHT_THR_RST);
                    no_idle = 1'b1;
                end
                default: begin
                    awake = THR_W'($urandom_range(0, 12000));
                    light = THR_W'($urandom_range(0, awake));
                end
            endcase
            set_thresholds(awake, light);
            for (i = 0; i < PHASE_ITEMS; i++)
                send_sample(random_sample());
            await_drain();
        end
    endtask

    // test sequence
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_window_fill();
        test_threshold_equal();
        test_drain_to_zero();
        test_backpressure();
        test_random_phases();
        await_drain();
        if (error_count == 0)
            $display("windowed_motion_sleep_classifier_tb: clean");
        else
            $display("windowed_motion_sleep_classifier_tb: errors");
        $finish;
    end

endmodule
